// ===== rtl/bdc_pkg.sv =====
package bdc_pkg;

	// Tick counter width; comparisons use the full counter value.
	localparam int TICK_BITS = 32;
	localparam int DIV_CNT_W = $clog2(TICK_BITS);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int THR_W = 16;
	localparam int NUM_EVB = 6;

	// Event mask bit positions, in emission order.
	localparam int EVB_PRESS   = 0;
	localparam int EVB_RELEASE = 1;
	localparam int EVB_HOLD    = 2;
	localparam int EVB_LONG    = 3;
	localparam int EVB_SERIAL  = 4;
	localparam int EVB_MULTI   = 5;

	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_LEVEL = 1'b1;

	typedef enum logic [3:0] {
		EV_PRESS     = 4'd0,
		EV_RELEASE   = 4'd1,
		EV_HOLD      = 4'd2,
		EV_LONG_HOLD = 4'd3,
		EV_SERIAL    = 4'd4,
		EV_SINGLE    = 4'd5,
		EV_DOUBLE    = 4'd6,
		EV_TRIPLE    = 4'd7,
		EV_QUAD      = 4'd8,
		EV_FIVEFOLD  = 4'd9
	} evt_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_LEVEL  = 3'd0,
		CFG_BUTTON_ID     = 3'd1,
		CFG_BOUNCE        = 3'd2,
		CFG_HOLD          = 3'd3,
		CFG_LONG_HOLD     = 3'd4,
		CFG_SERIAL_START  = 3'd5,
		CFG_SERIAL_PERIOD = 3'd6,
		CFG_CLICK_GAP     = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic mode;
		logic level;
	} item_t;

	typedef struct packed {
		logic [3:0] event_code;
		logic [7:0] source_id;
		logic       last;
	} evt_t;

endpackage

// ===== rtl/button_debounce_click_classifier.sv =====
// Button debounce and multi-click classifier.
//
// item channel (item_valid / item_stall / item): one request per timer tick
// (mode 0) or raw level change (mode 1, new level in item.level).
// evt channel (evt_valid / evt_stall / evt): zero to four events per tick,
// in order press/release, hold, long hold, serial, then the multi-click
// verdict; evt.last marks the final event of a tick.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
// writes, taken only while the block is idle and no request is offered.
//
// Timing: a level change is absorbed in the accept cycle, so level changes
// can follow each other every cycle. A tick passes through an evaluation
// state, then through the restoring remainder unit, which steps over all
// TICK_BITS dividend bits, when a serial repeat is possible (pressed, past
// serial start, nonzero period), then a load and a present state per event.
// item_stall stays high from the accepted tick until the last event is taken,
// including any output stall time. The remainder unit sets the worst case.
// A stalled event simply holds.
// Reset: released, counters cleared, raw level at the inactive level,
// registers at their defaults.
module button_debounce_click_classifier (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  bdc_pkg::item_t              item,
	output logic                        evt_valid,
	input  logic                        evt_stall,
	output bdc_pkg::evt_t               evt,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bdc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bdc_pkg::*;

	// configuration registers
	logic             active_level_q;
	logic [7:0]       button_id_q;
	logic [THR_W-1:0] bounce_q, hold_q, long_hold_q;
	logic [THR_W-1:0] serial_start_q, serial_period_q, click_gap_q;

	// button state
	logic                 raw_level_q;
	logic                 pressed_q;
	logic [TICK_BITS-1:0] tick_count_q;
	logic [7:0]           click_q;

	// sequencer and work registers
	state_t               state_q, state_next;
	logic [NUM_EVB-1:0]   ev_q;
	logic [3:0]           multi_code_q;
	logic [TICK_BITS-1:0] div_q;
	logic [THR_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	evt_t                 evt_q;

	logic item_acc, evt_acc, cfg_acc;

	// evaluation of one tick
	logic               bounce_hit, now_pressed, chg, pressed_new;
	logic [7:0]         click_inc;
	logic               gap_hit, serial_cand;
	logic [NUM_EVB-1:0] ev_eval;

	// remainder step
	logic [THR_W:0]   rem_shift, rem_step;
	logic             rem_ge, div_done, serial_hit;

	// event pick
	logic [NUM_EVB-1:0] pick_oh;
	logic [3:0]         pick_code;

	assign item_acc = item_valid && !item_stall;
	assign evt_acc  = evt_valid && !evt_stall;
	assign cfg_acc  = cfg_valid && cfg_ready;

	always_comb begin
		bounce_hit  = tick_count_q == TICK_BITS'(bounce_q);
		now_pressed = raw_level_q == active_level_q;
		chg         = bounce_hit && (now_pressed != pressed_q);
		pressed_new = chg ? now_pressed : pressed_q;
		click_inc   = click_q + 8'(chg && now_pressed);
		gap_hit     = tick_count_q >= TICK_BITS'(click_gap_q);
		serial_cand = pressed_new && (tick_count_q >= TICK_BITS'(serial_start_q))
			&& (serial_period_q != '0);
		ev_eval              = '0;
		ev_eval[EVB_PRESS]   = chg && now_pressed;
		ev_eval[EVB_RELEASE] = chg && !now_pressed;
		ev_eval[EVB_HOLD]    = pressed_new && (tick_count_q == TICK_BITS'(hold_q));
		ev_eval[EVB_LONG]    = pressed_new && (tick_count_q == TICK_BITS'(long_hold_q));
		ev_eval[EVB_MULTI]   = gap_hit && !pressed_new
			&& (click_inc >= 8'd1) && (click_inc <= 8'd5);
	end

	// one restoring remainder step per cycle, dividend MSB first
	always_comb begin
		rem_shift  = {rem_q, div_q[TICK_BITS-1]};
		rem_ge     = rem_shift >= {1'b0, serial_period_q};
		rem_step   = rem_ge ? (rem_shift - {1'b0, serial_period_q}) : rem_shift;
		div_done   = div_cnt_q == '0;
		serial_hit = rem_step == '0;
	end

	// lowest pending event bit goes out first
	always_comb begin
		pick_oh   = ev_q & (~ev_q + NUM_EVB'(1));
		pick_code = 4'(EV_PRESS);
		for (int i = 0; i < NUM_EVB; i++) begin
			if (pick_oh[i]) begin
				pick_code = (i == EVB_MULTI) ? multi_code_q : 4'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc && item.mode == MODE_TICK) state_next = ST_EVAL;
			end
			ST_EVAL: begin
				if (serial_cand) state_next = ST_DIV;
				else if (ev_eval != '0) state_next = ST_LOAD;
				else state_next = ST_IDLE;
			end
			ST_DIV: begin
				if (div_done) begin
					if (ev_q != '0 || serial_hit) state_next = ST_LOAD;
					else state_next = ST_IDLE;
				end
			end
			ST_LOAD: state_next = ST_EMIT;
			ST_EMIT: begin
				if (evt_acc) state_next = (ev_q != '0) ? ST_LOAD : ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// handshake outputs; a pending request keeps register writes out
	always_comb begin
		item_stall = state_q != ST_IDLE;
		cfg_ready  = (state_q == ST_IDLE) && !item_valid;
		evt_valid  = state_q == ST_EMIT;
	end

	assign evt = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			active_level_q  <= 1'b0;
			button_id_q     <= 8'd0;
			bounce_q        <= THR_W'(5);
			hold_q          <= THR_W'(100);
			long_hold_q     <= THR_W'(300);
			serial_start_q  <= THR_W'(100);
			serial_period_q <= THR_W'(10);
			click_gap_q     <= THR_W'(30);
			raw_level_q     <= 1'b1;
			pressed_q       <= 1'b0;
			tick_count_q    <= '0;
			click_q         <= '0;
			ev_q            <= '0;
			div_cnt_q       <= '0;
		end else begin
			state_q <= state_next;

			if (cfg_acc) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_ACTIVE_LEVEL: begin
						active_level_q <= cfg_data[0];
						raw_level_q    <= ~cfg_data[0];
					end
					CFG_BUTTON_ID:     button_id_q     <= cfg_data[7:0];
					CFG_BOUNCE:        bounce_q        <= cfg_data;
					CFG_HOLD:          hold_q          <= cfg_data;
					CFG_LONG_HOLD:     long_hold_q     <= cfg_data;
					CFG_SERIAL_START:  serial_start_q  <= cfg_data;
					CFG_SERIAL_PERIOD: serial_period_q <= cfg_data;
					CFG_CLICK_GAP:     click_gap_q     <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (item.mode == MODE_LEVEL) begin
							raw_level_q  <= item.level;
							tick_count_q <= '0;
						end else begin
							tick_count_q <= tick_count_q + TICK_BITS'(1);
						end
					end
				end
				ST_EVAL: begin
					pressed_q <= pressed_new;
					click_q   <= gap_hit ? 8'd0 : click_inc;
					ev_q      <= ev_eval;
					div_cnt_q <= DIV_CNT_W'(TICK_BITS - 1);
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					if (div_done) ev_q[EVB_SERIAL] <= serial_hit;
				end
				ST_LOAD: ev_q <= ev_q & ~pick_oh;
				ST_EMIT: ;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			multi_code_q <= 4'(EV_SERIAL) + click_inc[3:0];
			div_q        <= tick_count_q;
			rem_q        <= '0;
		end else if (state_q == ST_DIV) begin
			div_q <= div_q << 1;
			rem_q <= rem_step[THR_W-1:0];
		end
		if (state_q == ST_LOAD) begin
			evt_q.event_code <= pick_code;
			evt_q.source_id  <= button_id_q;
			evt_q.last       <= (ev_q & ~pick_oh) == '0;
		end
	end

	a_tick_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && item.mode == MODE_TICK |=> state_q == ST_EVAL)
		else $error("tick did not enter evaluation");

	a_level_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && item.mode == MODE_LEVEL |=> tick_count_q == '0 && state_q == ST_IDLE)
		else $error("level change did not clear tick counter");

	a_div_period: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> serial_period_q != '0)
		else $error("remainder unit running with zero period");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		evt_acc && evt.last |=> state_q == ST_IDLE)
		else $error("events continue after last");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		evt_acc && !evt.last |=> state_q == ST_LOAD)
		else $error("pending events dropped");

endmodule
